// ----- src/lnds_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// lnds_pkg: shared definitions for the longest non-decreasing subsequence block
// Constants, result word layout and RAM control bundle used by all modules.
// ============================================================================
package lnds_pkg;

    // Default table depth and working key width.
    localparam int MAX_TAILS_DEF  = 1024;
    localparam int VALUE_BITS_DEF = 32;

    // Fixed field widths of the stream words.
    localparam int SAMPLE_W   = 32;
    localparam int LEN_W      = 11;
    localparam int OUT_DATA_W = 16;

    // One result word as handed from the search engine to the output register.
    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic             final_item;
        logic             overflow;
    } lnds_result_t;

    // Strobes from the search engine to the tail RAM.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } lnds_ram_ctl_t;

endpackage

// ----- src/lnds_tail_ram.sv -----
`timescale 1ns / 1ps
// ============================================================================
// lnds_tail_ram: tail table storage
// Simple dual-port RAM, one write and one registered read per cycle.
// ============================================================================
module lnds_tail_ram #(
    parameter int DEPTH  = lnds_pkg::MAX_TAILS_DEF,
    parameter int WIDTH  = lnds_pkg::VALUE_BITS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                   clk,
    input  lnds_pkg::lnds_ram_ctl_t ctl,
    input  logic [ADDR_W-1:0]      rd_addr,
    output logic [WIDTH-1:0]       rd_data,
    input  logic [ADDR_W-1:0]      wr_addr,
    input  logic [WIDTH-1:0]       wr_data
);
    import lnds_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- src/lnds_search.sv -----
`timescale 1ns / 1ps
// ============================================================================
// lnds_search: binary search sequencer over the tail table
// Runs one compare per cycle against the RAM, then replaces or appends a tail, or drops the append when full.
// ============================================================================
module lnds_search #(
    parameter int MAX_TAILS  = lnds_pkg::MAX_TAILS_DEF,
    parameter int VALUE_BITS = lnds_pkg::VALUE_BITS_DEF,
    parameter int ADDR_W     = $clog2(MAX_TAILS)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [lnds_pkg::SAMPLE_W-1:0]   sample,
    input  logic                            last,
    output logic                            res_valid,
    input  logic                            res_ready,
    output lnds_pkg::lnds_result_t          result,
    output lnds_pkg::lnds_ram_ctl_t         ram_ctl,
    output logic [ADDR_W-1:0]               rd_addr,
    input  logic [VALUE_BITS-1:0]           rd_data,
    output logic [ADDR_W-1:0]               wr_addr,
    output logic [VALUE_BITS-1:0]           wr_data
);
    import lnds_pkg::*;

    localparam int CW = $clog2(MAX_TAILS + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_TAILS);
    localparam logic [VALUE_BITS-1:0] SIGN_FLIP = {1'b1, {(VALUE_BITS - 1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_STEP  = 3'b010,
        S_WRITE = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                overflow_reg, overflow_next;
    logic [CW-1:0]       lo_reg, lo_next;
    logic [CW-1:0]       hi_reg, hi_next;
    logic [CW-1:0]       mid_reg, mid_next;
    logic [VALUE_BITS-1:0] key_reg, key_next;
    logic                last_reg, last_next;

    logic                accept;
    logic                greater;
    logic [CW-1:0]       lo_step, hi_step;
    logic [CW:0]         mid_sum;
    logic                full;
    logic [CW-1:0]       count_after;
    logic                overflow_after;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    // Keys are stored with the sign bit flipped so unsigned order is signed order.
    assign greater  = (rd_data > key_reg);
    assign lo_step  = greater ? lo_reg : (mid_reg + CW'(1));
    assign hi_step  = greater ? mid_reg : hi_reg;
    assign mid_sum  = {1'b0, lo_step} + {1'b0, hi_step};
    assign full     = (count_reg == FULL_COUNT);

    // Append when the search ran off the end, unless the table is full.
    assign count_after    = ((lo_reg == count_reg) && !full) ? (count_reg + CW'(1)) : count_reg;
    assign overflow_after = overflow_reg || ((lo_reg == count_reg) && full);

    assign res_valid         = (state_reg == S_WRITE);
    assign result.length     = LEN_W'(count_after);
    assign result.final_item = last_reg;
    assign result.overflow   = overflow_after;

    assign wr_addr = lo_reg[ADDR_W-1:0];
    assign wr_data = key_reg;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        key_next      = key_reg;
        last_next     = last_reg;
        ram_ctl.rd_en = 1'b0;
        ram_ctl.wr_en = 1'b0;
        rd_addr       = mid_reg[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next  = VALUE_BITS'(sample) ^ SIGN_FLIP;
                    last_next = last;
                    lo_next   = '0;
                    hi_next   = count_reg;
                    mid_next  = count_reg >> 1;
                    rd_addr   = mid_next[ADDR_W-1:0];
                    if (count_reg != '0)
                    begin
                        ram_ctl.rd_en = 1'b1;
                        state_next    = S_STEP;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
            end
            S_STEP:
            begin
                lo_next  = lo_step;
                hi_next  = hi_step;
                mid_next = mid_sum[CW:1];
                rd_addr  = mid_next[ADDR_W-1:0];
                if (lo_step < hi_step)
                begin
                    ram_ctl.rd_en = 1'b1;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                if (res_ready)
                begin
                    ram_ctl.wr_en = !((lo_reg == count_reg) && full);
                    if (last_reg)
                    begin
                        count_next    = '0;
                        overflow_next = 1'b0;
                    end
                    else
                    begin
                        count_next    = count_after;
                        overflow_next = overflow_after;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        key_reg  <= key_next;
        last_reg <= last_next;
    end

endmodule

// ----- src/longest_nondecreasing_subseq_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// longest_nondecreasing_subseq_top: streaming longest non-decreasing subsequence
// Patience-style tail table with a binary search engine and an output register.
// ============================================================================
// Usage:
//   The slave channel takes one word per sample: s_axis_tdata carries the
//   signed value and s_axis_tlast marks the final sample of a sequence.
//   For every accepted word the master channel returns exactly one word:
//   the longest non-decreasing subsequence length so far, tlast copied
//   from the input, and tuser set once an append was dropped because the
//   tail table was full.
//   The binary search does one tail RAM read and compare per cycle over
//   the tails stored, and a new item is taken only after the last one
//   has been handed to the output register.
//   s_axis_tready is high only while the search engine is idle.
//   Reset clears the tail count and the overflow flag; the tail RAM holds
//   no reset value and is only read below the count. After a word with
//   tlast the sequence state clears for the next sequence.
//   If the receiver stalls, the result waits in the output register and
//   the engine holds its finished item until that register frees up.
// ============================================================================
module longest_nondecreasing_subseq_top #(
    parameter int MAX_TAILS  = lnds_pkg::MAX_TAILS_DEF,
    parameter int VALUE_BITS = lnds_pkg::VALUE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: [31:0] sample_value
    input  logic [lnds_pkg::SAMPLE_W-1:0]       s_axis_tdata,
    // tlast: end_of_sequence
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: [10:0] longest_length, [15:11] zero
    output logic [lnds_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // tlast: final_result
    output logic                                m_axis_tlast,
    // tuser: [0] capacity_overflow
    output logic                                m_axis_tuser
);
    import lnds_pkg::*;

    localparam int ADDR_W = $clog2(MAX_TAILS);

    // Engine to RAM connections.
    lnds_ram_ctl_t         ram_ctl;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     wr_addr;
    logic [VALUE_BITS-1:0] rd_data;
    logic [VALUE_BITS-1:0] wr_data;

    // Engine to output register handoff.
    lnds_result_t result;
    logic         res_valid;
    logic         res_ready;

    logic         m_valid_reg, m_valid_next;
    lnds_result_t m_word_reg;

    lnds_tail_ram #(
        .DEPTH  (MAX_TAILS),
        .WIDTH  (VALUE_BITS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .ctl     (ram_ctl),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    lnds_search #(
        .MAX_TAILS  (MAX_TAILS),
        .VALUE_BITS (VALUE_BITS),
        .ADDR_W     (ADDR_W)
    ) u_search (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .sample    (s_axis_tdata),
        .last      (s_axis_tlast),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .result    (result),
        .ram_ctl   (ram_ctl),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // The output register takes a new word whenever it is empty or being drained.
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    // The payload needs no reset; it is only looked at while valid is high.
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_word_reg <= result;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(m_word_reg.length);
    assign m_axis_tlast  = m_word_reg.final_item;
    assign m_axis_tuser  = m_word_reg.overflow;

    // The engine never offers a result while it is also ready for a new sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(res_valid && s_axis_tready))
    else $error("search engine ready while holding a result");

    // Accepting a sample always makes the engine busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("engine accepted back-to-back samples");

    // A handed-off result must show up on the master channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> m_axis_tvalid)
    else $error("result handoff lost");

    // Every item counts, so the reported length is never zero unless it wraps.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (MAX_TAILS < 2048)) |-> (m_axis_tdata[LEN_W-1:0] != '0))
    else $error("zero length reported");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking testbench for longest_nondecreasing_subseq_top
// Streams sequences of signed samples into the block and checks each result
// word against a tail-table prediction. Directed corner sequences come first.
// Random sequences follow, including one long enough to fill the table. The
// run cycles through phases of source gaps and sink back-pressure.
// ============================================================================
module tb;

    import lnds_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int TABLE_DEPTH  = MAX_TAILS_DEF;
    // Total sample budget for the random part, the table-filling run included.
    localparam int RANDOM_ITEMS = 2000;
    localparam int FILL_ITEMS   = TABLE_DEPTH + TABLE_DEPTH / 4;
    // Gaps and stalls at 75 percent rarely hold the stream up for long, so
    // this limit leaves a wide margin.
    localparam int STUCK_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;

    localparam logic signed [SAMPLE_W-1:0] VALUE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] VALUE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

    // Shapes of random sequences. Rising runs build long tables, narrow
    // runs produce many equal values, falling runs keep the table short.
    typedef enum int {
        SEQ_SCATTER,
        SEQ_NARROW,
        SEQ_RISING,
        SEQ_FALLING,
        SEQ_NOISY_RISE
    } seq_kind_t;

    // ------------------------------------------------------------------------
    // Expected result words. The class keeps its own sorted tail table: each
    // accepted sample is placed at the first tail strictly greater than it,
    // or appended, and the resulting length is queued for the sink side.
    // ------------------------------------------------------------------------
    class subseq_length_board;
        logic signed [SAMPLE_W-1:0] tails [TABLE_DEPTH];
        int                         tail_count;
        bit                         overflow_seen;
        lnds_result_t               expected_lengths [$];
        int                         errors;

        function new();
            tail_count    = 0;
            overflow_seen = 1'b0;
            errors        = 0;
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] value, logic last);
            int           lo;
            int           hi;
            int           mid;
            lnds_result_t word;
            lo = 0;
            hi = tail_count;
            // Binary search for the first tail strictly greater than value,
            // so equal tails are skipped and equal samples extend the run.
            while (lo < hi)
            begin
                mid = (lo + hi) / 2;
                if (tails[mid] > value)
                    hi = mid;
                else
                    lo = mid + 1;
            end
            if (lo < tail_count)
                tails[lo] = value;
            else if (tail_count < TABLE_DEPTH)
            begin
                tails[tail_count] = value;
                tail_count++;
            end
            else
                overflow_seen = 1'b1;
            word.length     = LEN_W'(tail_count);
            word.final_item = last;
            word.overflow   = overflow_seen;
            expected_lengths.insert(expected_lengths.size(), word);
            // The last sample is reported before the sequence state clears.
            if (last)
            begin
                tail_count    = 0;
                overflow_seen = 1'b0;
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic last, logic user);
            lnds_result_t want;
            if (expected_lengths.size() == 0)
            begin
                $error("unexpected result word: tdata=%0h tlast=%0b tuser=%0b", data, last, user);
                errors++;
                return;
            end
            want = expected_lengths.pop_front();
            if (data[LEN_W-1:0] !== want.length)
            begin
                $error("longest_length: expected %0d, actual %0d", want.length, data[LEN_W-1:0]);
                errors++;
            end
            if (data[OUT_DATA_W-1:LEN_W] !== '0)
            begin
                $error("tdata padding: expected 0, actual %0h", data[OUT_DATA_W-1:LEN_W]);
                errors++;
            end
            if (last !== want.final_item)
            begin
                $error("final_result: expected %0b, actual %0b", want.final_item, last);
                errors++;
            end
            if (user !== want.overflow)
            begin
                $error("capacity_overflow: expected %0b, actual %0b", want.overflow, user);
                errors++;
            end
        endfunction

        function int pending();
            return expected_lengths.size();
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [SAMPLE_W-1:0]         s_axis_tdata;
    logic                        s_axis_tlast;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [OUT_DATA_W-1:0]       m_axis_tdata;
    logic                        m_axis_tlast;
    logic                        m_axis_tuser;

    subseq_length_board length_board;

    // Percentages of cycles in which the source holds back a word and the
    // sink refuses one. The main sequence changes them per phase.
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int stuck_cycles  = 0;

    longest_nondecreasing_subseq_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Sends one word. tvalid is left high after the handshake, so the next
    // call either presents its word at once or drops tvalid for a gap.
    task automatic send_word(input logic signed [SAMPLE_W-1:0] value, input logic last);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        length_board.note_sample(value, last);
    endtask

    // Sends a whole sequence of the given shape; its last word carries tlast.
    task automatic send_sequence(input seq_kind_t kind, input int len);
        longint                     level;
        logic signed [SAMPLE_W-1:0] sample;
        // Rising runs start in the lower half and falling runs in the upper
        // half, so long runs have room before they pin at an extreme.
        case (kind)
            SEQ_FALLING: level = longint'(VALUE_MAX) - longint'($urandom_range(0, 32'h7fff_ffff));
            default:     level = longint'(VALUE_MIN) + longint'($urandom_range(0, 32'h7fff_ffff));
        endcase
        for (int i = 0; i < len; i++)
        begin
            case (kind)
                SEQ_SCATTER: level = longint'($signed($urandom()));
                SEQ_NARROW:  level = longint'($urandom_range(0, 6)) - 3;
                SEQ_FALLING: level = level - ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 1000));
                default:     level = level + ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 1000));
            endcase
            // Pinning at the extremes turns the tail of a run into equal values.
            if (level > longint'(VALUE_MAX))
                level = longint'(VALUE_MAX);
            if (level < longint'(VALUE_MIN))
                level = longint'(VALUE_MIN);
            sample = SAMPLE_W'(level);
            // Occasional out-of-order values replace tails instead of appending.
            if (kind == SEQ_NOISY_RISE && $urandom_range(0, 7) == 0)
                sample = $urandom();
            send_word(sample, i == len - 1);
        end
    endtask

    // Sink side: checks every accepted result word and randomizes tready.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                length_board.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Watchdog: a run that accepts nothing on either side for too long is
    // treated as hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("longest_nondecreasing_subseq_top regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int src_phase_pct  [4];
        int sink_phase_pct [4];
        int fill_phase;
        int phase_items;
        int len;
        length_board   = new();
        // Phases: no idling, source gaps, sink stalls, then light gaps on both.
        src_phase_pct  = '{0, 75, 0, 13};
        sink_phase_pct = '{0, 0, 75, 13};
        fill_phase     = $urandom_range(0, 3);

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A sequence of a single word reports length one and clears.
        send_word(32'sd5, 1'b1);

        // Field extremes: the minimum replaces the maximum, equal minimums
        // extend the run, repeated maximums extend it again, and the closing
        // word replaces a tail without growing the table.
        send_word(VALUE_MAX, 1'b0);
        send_word(VALUE_MIN, 1'b0);
        send_word(VALUE_MIN, 1'b0);
        send_word(-32'sd1, 1'b0);
        send_word(32'sd0, 1'b0);
        send_word(32'sd0, 1'b0);
        send_word(VALUE_MAX, 1'b0);
        send_word(VALUE_MAX, 1'b0);
        send_word(32'sd1, 1'b1);

        // Strictly falling values never get past length one.
        send_word(32'sd40, 1'b0);
        send_word(32'sd30, 1'b0);
        send_word(32'sd20, 1'b0);
        send_word(32'sd10, 1'b0);
        send_word(-32'sd10, 1'b1);

        // A run of equal values counts every element.
        send_word(32'sd7, 1'b0);
        send_word(32'sd7, 1'b0);
        send_word(32'sd7, 1'b0);
        send_word(32'sd7, 1'b1);

        for (int phase = 0; phase < 4; phase++)
        begin
            src_idle_pct   = src_phase_pct[phase];
            sink_stall_pct = sink_phase_pct[phase];
            phase_items    = 0;
            // One phase carries a run long enough to fill the tail table,
            // after which appends are dropped and the overflow flag sticks.
            if (phase == fill_phase)
                send_sequence(SEQ_NOISY_RISE, FILL_ITEMS);
            while (phase_items < (RANDOM_ITEMS - FILL_ITEMS) / 4)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 150)
                                                  : $urandom_range(1, 40);
                send_sequence(seq_kind_t'($urandom_range(0, 4)), len);
                phase_items += len;
            end
        end

        s_axis_tvalid <= 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        while (length_board.pending() != 0)
            @(posedge clk);
        // Let any stray word surface before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (length_board.errors == 0 && length_board.pending() == 0)
            $display("longest_nondecreasing_subseq_top regression: pass");
        else
            $display("longest_nondecreasing_subseq_top regression: fail");
        $finish;
    end

endmodule
